FILE: sv/csc_pkg.sv
`timescale 1ns / 1ps

package csc_pkg;

  localparam int MEMO_INDEX_BITS = 16;
  localparam int MEMO_DEPTH      = 1 << MEMO_INDEX_BITS;

  localparam logic [31:0]  MEMO_UNKNOWN = 32'hFFFF_FFFF;
  localparam logic [31:0]  FUSE_DEFAULT = 32'd100000;
  localparam logic [32:0]  STEPS_MAX    = 33'h1_FFFF_FFFF;
  // Largest value whose 3n+1 still fits in 128 bits: (2^128-4)/3.
  localparam logic [127:0] SAFE_LIMIT   = {64'h5555_5555_5555_5555, 64'h5555_5555_5555_5554};

  localparam logic FUNC_MEMO_WRITE = 1'b0;
  localparam logic FUNC_SEED       = 1'b1;

  typedef enum logic [1:0] {
    STATUS_DONE     = 2'd0,
    STATUS_FUSE     = 2'd1,
    STATUS_OVERFLOW = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_CHECK,
    S_LOOKUP,
    S_MAP,
    S_STRIP
  } state_t;

  typedef struct packed {
    logic    clear;
    logic    mem_write;
    logic    load;
    logic    map;
    logic    strip;
    logic    finish;
    logic    add_cached;
    status_t fin_status;
  } csc_cmd_t;

  typedef struct packed {
    logic clear_last;
    logic at_end;
    logic fuse;
    logic below_table;
    logic memo_hit;
    logic odd;
    logic overflow;
    logic strip_more;
  } csc_stat_t;

endpackage

FILE: sv/csc_ram.sv
`timescale 1ns / 1ps

module csc_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 65536,
  localparam int ABITS = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [ABITS-1:0] waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [ABITS-1:0] raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: sv/csc_dp.sv
`timescale 1ns / 1ps

module csc_dp (
  input  logic                 clk,
  input  logic                 rst,
  input  csc_pkg::csc_cmd_t    cmd,
  output csc_pkg::csc_stat_t   stat,
  input  logic                 cfg_write,
  input  logic [31:0]          cfg_data,
  input  logic [63:0]          seed_low,
  input  logic [63:0]          seed_high,
  input  logic [15:0]          memo_index,
  input  logic [31:0]          memo_value,
  output logic                 done,
  output logic [32:0]          steps,
  output logic [63:0]          peak_low,
  output logic [63:0]          peak_high,
  output logic [1:0]           status
);

  localparam int MIB = csc_pkg::MEMO_INDEX_BITS;

  logic [127:0]   walk, walk_next;
  logic [32:0]    count, count_next;
  logic [127:0]   peak, peak_upd;
  logic [31:0]    fuse_limit;
  logic [MIB-1:0] clear_addr;
  logic [127:0]   triple;
  logic [3:0]     tz_k;
  logic [33:0]    total;
  logic [32:0]    steps_fin;

  logic           ram_we;
  logic [MIB-1:0] ram_waddr;
  logic [31:0]    ram_wdata;
  logic [31:0]    ram_rdata;

  always_ff @(posedge clk) begin
    if (rst) begin
      fuse_limit <= csc_pkg::FUSE_DEFAULT;
    end else if (cfg_write) begin
      fuse_limit <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clear_addr <= '0;
    end else if (cmd.clear) begin
      clear_addr <= clear_addr + 1'b1;
    end
  end

  assign ram_we    = cmd.clear | cmd.mem_write;
  assign ram_waddr = cmd.clear ? clear_addr : MIB'(memo_index);
  assign ram_wdata = cmd.clear ? csc_pkg::MEMO_UNKNOWN : memo_value;

  csc_ram #(
    .WIDTH(32),
    .DEPTH(csc_pkg::MEMO_DEPTH)
  ) u_memo (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(walk[MIB-1:0]),
    .rdata(ram_rdata)
  );

  // Trailing zeros are stripped up to one byte per cycle; a zero low byte asks for another pass.
  always_comb begin
    tz_k = 4'd8;
    for (int i = 7; i >= 0; i--) begin
      if (walk[i]) begin
        tz_k = 4'(i);
      end
    end
  end

  assign triple = walk + {walk[126:0], 1'b0} + 128'd1;

  always_comb begin
    walk_next  = walk;
    count_next = count;
    if (cmd.load) begin
      walk_next  = {seed_high, seed_low};
      count_next = '0;
    end else if (cmd.map && walk[0]) begin
      walk_next  = triple;
      count_next = count + 33'd1;
    end else if (cmd.strip) begin
      walk_next  = walk >> tz_k;
      count_next = count + 33'(tz_k);
    end
  end

  assign peak_upd = (cmd.map && (walk > peak)) ? walk : peak;

  always_ff @(posedge clk) begin
    walk  <= walk_next;
    count <= count_next;
    if (cmd.load) begin
      peak <= {seed_high, seed_low};
    end else begin
      peak <= peak_upd;
    end
  end

  assign total     = {1'b0, count} + (cmd.add_cached ? {2'b00, ram_rdata} : 34'd0);
  assign steps_fin = total[33] ? csc_pkg::STEPS_MAX : total[32:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= cmd.finish;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      steps     <= steps_fin;
      peak_low  <= peak_upd[63:0];
      peak_high <= peak_upd[127:64];
      status    <= cmd.fin_status;
    end
  end

  always_comb begin
    stat.clear_last  = (clear_addr == {MIB{1'b1}});
    stat.at_end      = (walk[127:1] == '0);
    stat.fuse        = (count >= {1'b0, fuse_limit});
    stat.below_table = (walk[127:MIB] == '0);
    stat.memo_hit    = (ram_rdata != csc_pkg::MEMO_UNKNOWN);
    stat.odd         = walk[0];
    stat.overflow    = (walk > csc_pkg::SAFE_LIMIT);
    stat.strip_more  = (walk[7:0] == 8'd0);
  end

  // The walk never holds zero while trailing zeros are being stripped.
  a_strip_nonzero: assert property (@(posedge clk) disable iff (rst)
    cmd.strip |-> (walk != '0))
    else $error("strip on a zero walk value");

  // A new walk must pass through the idle and check states before it finishes, so results never come back to back.
  a_done_gap: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("result strobes in consecutive cycles");

endmodule

FILE: sv/csc_ctrl.sv
`timescale 1ns / 1ps

module csc_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic               func,
  input  csc_pkg::csc_stat_t stat,
  output csc_pkg::csc_cmd_t  cmd,
  output logic               busy
);

  csc_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= csc_pkg::S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next     = state;
    cmd            = '0;
    cmd.fin_status = csc_pkg::STATUS_DONE;
    unique case (state)
      csc_pkg::S_CLEAR: begin
        cmd.clear = 1'b1;
        if (stat.clear_last) begin
          state_next = csc_pkg::S_IDLE;
        end
      end
      csc_pkg::S_IDLE: begin
        if (start) begin
          if (func == csc_pkg::FUNC_SEED) begin
            cmd.load   = 1'b1;
            state_next = csc_pkg::S_CHECK;
          end else begin
            cmd.mem_write = 1'b1;
          end
        end
      end
      csc_pkg::S_CHECK: begin
        priority if (stat.at_end) begin
          cmd.finish = 1'b1;
          state_next = csc_pkg::S_IDLE;
        end else if (stat.fuse) begin
          cmd.finish     = 1'b1;
          cmd.fin_status = csc_pkg::STATUS_FUSE;
          state_next     = csc_pkg::S_IDLE;
        end else if (stat.below_table) begin
          state_next = csc_pkg::S_LOOKUP;
        end else begin
          state_next = csc_pkg::S_MAP;
        end
      end
      csc_pkg::S_LOOKUP: begin
        if (stat.memo_hit) begin
          cmd.finish     = 1'b1;
          cmd.add_cached = 1'b1;
          state_next     = csc_pkg::S_IDLE;
        end else begin
          state_next = csc_pkg::S_MAP;
        end
      end
      csc_pkg::S_MAP: begin
        cmd.map = 1'b1;
        if (stat.odd && stat.overflow) begin
          cmd.finish     = 1'b1;
          cmd.fin_status = csc_pkg::STATUS_OVERFLOW;
          state_next     = csc_pkg::S_IDLE;
        end else begin
          state_next = csc_pkg::S_STRIP;
        end
      end
      csc_pkg::S_STRIP: begin
        cmd.strip = 1'b1;
        if (!stat.strip_more) begin
          state_next = csc_pkg::S_CHECK;
        end
      end
      default: begin
        state_next = csc_pkg::S_IDLE;
      end
    endcase
  end

  assign busy = (state != csc_pkg::S_IDLE);

  // The memo data is registered, so a lookup always follows the check that addressed it.
  a_lookup_after_check: assert property (@(posedge clk) disable iff (rst)
    (state == csc_pkg::S_LOOKUP) |-> ($past(state) == csc_pkg::S_CHECK))
    else $error("lookup without a preceding check");

endmodule

FILE: sv/collatz_step_count_memo.sv
`timescale 1ns / 1ps

// Collatz step counter with a memo table. A request is taken when start is high and busy is
// low: func 0 writes one memo entry in that single cycle, func 1 walks a 128-bit seed. The
// result of a walk appears on steps, peak_low, peak_high and status, marked by done for
// exactly one cycle; the receiver cannot stall it and must capture it in that cycle. A walk
// loads the seed, then for every map step passes through a check, a memo lookup when the
// value is below the table size, a map and strip passes that remove trailing zeros, up to
// one byte of zeros per cycle; the result strobe comes in the cycle after the final
// decision. After reset the memo table is cleared, all 2^16 entries, one entry per cycle
// through its single write port, during which busy stays high; writes of the step limit are
// taken at any time.
module collatz_step_count_memo (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic        func,
  input  logic [63:0] seed_low,
  input  logic [63:0] seed_high,
  input  logic [15:0] memo_index,
  input  logic [31:0] memo_value,
  input  logic        cfg_write,
  input  logic [31:0] cfg_data,
  output logic        done,
  output logic [32:0] steps,
  output logic [63:0] peak_low,
  output logic [63:0] peak_high,
  output logic [1:0]  status
);

  csc_pkg::csc_cmd_t  cmd;
  csc_pkg::csc_stat_t stat;

  csc_ctrl u_ctrl (
    .clk  (clk),
    .rst  (rst),
    .start(start),
    .func (func),
    .stat (stat),
    .cmd  (cmd),
    .busy (busy)
  );

  csc_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .stat      (stat),
    .cfg_write (cfg_write),
    .cfg_data  (cfg_data),
    .seed_low  (seed_low),
    .seed_high (seed_high),
    .memo_index(memo_index),
    .memo_value(memo_value),
    .done      (done),
    .steps     (steps),
    .peak_low  (peak_low),
    .peak_high (peak_high),
    .status    (status)
  );

endmodule

FILE: verif/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

  localparam int PHASE_ITEMS = 220;

  typedef struct {
    bit        func;
    bit [63:0] seed_low;
    bit [63:0] seed_high;
    bit [15:0] memo_index;
    bit [31:0] memo_value;
  } request_t;

  typedef struct {
    bit [32:0]        steps;
    bit [127:0]       peak;
    csc_pkg::status_t status;
  } walk_result_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  logic        busy;
  logic        func = 1'b0;
  logic [63:0] seed_low = '0;
  logic [63:0] seed_high = '0;
  logic [15:0] memo_index = '0;
  logic [31:0] memo_value = '0;
  logic        cfg_write = 1'b0;
  logic [31:0] cfg_data = '0;
  logic        done;
  logic [32:0] steps;
  logic [63:0] peak_low;
  logic [63:0] peak_high;
  logic [1:0]  status;

  request_t     pending_requests[$];
  walk_result_t walk_results[$];
  request_t     cur_req;
  bit [31:0]    memo_copy [csc_pkg::MEMO_DEPTH];
  bit [31:0]    step_limit = csc_pkg::FUSE_DEFAULT;
  int           idle_pct = 22;
  int           mismatch_count = 0;

  collatz_step_count_memo i_dut (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .busy       (busy),
    .func       (func),
    .seed_low   (seed_low),
    .seed_high  (seed_high),
    .memo_index (memo_index),
    .memo_value (memo_value),
    .cfg_write  (cfg_write),
    .cfg_data   (cfg_data),
    .done       (done),
    .steps      (steps),
    .peak_low   (peak_low),
    .peak_high  (peak_high),
    .status     (status)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Walks one seed the way the block should, against the shadow memo table and step limit.
  function automatic walk_result_t walk_seed(bit [127:0] seed);
    walk_result_t r;
    bit [127:0]   v;
    bit [63:0]    count;
    bit [63:0]    total;
    v        = seed;
    count    = 0;
    total    = 0;
    r.peak   = seed;
    r.status = csc_pkg::STATUS_DONE;
    if (seed > 1) begin
      forever begin
        if (v == 1) begin
          total = count;
          break;
        end
        if (count >= step_limit) begin
          r.status = csc_pkg::STATUS_FUSE;
          total = count;
          break;
        end
        if (v < csc_pkg::MEMO_DEPTH &&
            memo_copy[v[csc_pkg::MEMO_INDEX_BITS-1:0]] != csc_pkg::MEMO_UNKNOWN) begin
          total = count + memo_copy[v[csc_pkg::MEMO_INDEX_BITS-1:0]];
          break;
        end
        if (v > r.peak) r.peak = v;
        if (v[0]) begin
          if (v > csc_pkg::SAFE_LIMIT) begin
            r.status = csc_pkg::STATUS_OVERFLOW;
            total = count;
            break;
          end
          v = v * 3 + 1;
          count++;
        end
        while (!v[0]) begin
          v = v >> 1;
          count++;
        end
      end
    end
    if (total > csc_pkg::STEPS_MAX) total = csc_pkg::STEPS_MAX;
    r.steps = total[32:0];
    return r;
  endfunction

  task automatic flag_mismatch(input string field, input logic [127:0] want,
                               input logic [127:0] got);
    $display("%0t: mismatch on %s: expected %h, got %h", $time, field, want, got);
    mismatch_count++;
  endtask

  task automatic queue_seed(input bit [127:0] seed);
    request_t req;
    req.func       = csc_pkg::FUNC_SEED;
    req.seed_low   = seed[63:0];
    req.seed_high  = seed[127:64];
    req.memo_index = 16'($urandom);
    req.memo_value = $urandom;
    pending_requests.insert(pending_requests.size(), req);
  endtask

  task automatic queue_memo(input bit [15:0] idx, input bit [31:0] val);
    request_t req;
    req.func       = csc_pkg::FUNC_MEMO_WRITE;
    req.seed_low   = {$urandom, $urandom};
    req.seed_high  = {$urandom, $urandom};
    req.memo_index = idx;
    req.memo_value = val;
    pending_requests.insert(pending_requests.size(), req);
  endtask

  task automatic queue_random_request();
    int         pick;
    int         width_bits;
    bit [127:0] seed;
    bit [15:0]  idx;
    bit [31:0]  val;
    if ($urandom_range(99) < 25) begin
      idx = ($urandom_range(1)) ? 16'($urandom_range(1023)) : 16'($urandom_range(65535));
      pick = $urandom_range(99);
      if (pick < 10) val = csc_pkg::MEMO_UNKNOWN;
      else if (pick < 20) val = $urandom;
      else val = $urandom_range(3000);
      queue_memo(idx, val);
    end else begin
      pick = $urandom_range(99);
      seed = {$urandom, $urandom, $urandom, $urandom};
      // Mostly short seeds so that walks land in the memo range quickly.
      if (pick < 80) begin
        width_bits = (pick < 55) ? $urandom_range(1, 20) : $urandom_range(21, 64);
        seed = (seed & ((128'd1 << width_bits) - 1)) | (128'd1 << (width_bits - 1));
      end else if (pick < 93) begin
        seed = seed;
      end else if (pick < 97) begin
        seed = csc_pkg::SAFE_LIMIT - 8 + $urandom_range(16);
      end else begin
        case ($urandom_range(3))
          0: seed = '0;
          1: seed = 128'd1;
          2: seed = '1;
          default: seed = 128'd1 << $urandom_range(127);
        endcase
      end
      queue_seed(seed);
    end
  endtask

  // Waits until every request is taken and every result is back, then lets the block settle.
  task automatic wait_for_drain();
    do @(negedge clk);
    while (pending_requests.size() != 0 || start || walk_results.size() != 0);
    repeat (20) @(negedge clk);
  endtask

  task automatic set_step_limit(input bit [31:0] limit);
    wait_for_drain();
    @(posedge clk);
    cfg_write <= 1'b1;
    cfg_data  <= limit;
    @(posedge clk);
    cfg_write <= 1'b0;
    step_limit = limit;
  endtask

  always @(posedge clk) begin : drive_requests
    request_t next_req;
    if (rst) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) begin
        if (cur_req.func == csc_pkg::FUNC_SEED) begin
          walk_results.insert(walk_results.size(),
                              walk_seed({cur_req.seed_high, cur_req.seed_low}));
        end else begin
          memo_copy[cur_req.memo_index[csc_pkg::MEMO_INDEX_BITS-1:0]] = cur_req.memo_value;
        end
      end
      // A raised request stays up until it is taken.
      if (!start || !busy) begin
        if (pending_requests.size() != 0 && $urandom_range(99) >= idle_pct) begin
          next_req   = pending_requests.pop_front();
          cur_req    = next_req;
          start      <= 1'b1;
          func       <= next_req.func;
          seed_low   <= next_req.seed_low;
          seed_high  <= next_req.seed_high;
          memo_index <= next_req.memo_index;
          memo_value <= next_req.memo_value;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin : check_results
    walk_result_t want;
    if (!rst && done) begin
      if (walk_results.size() == 0) begin
        flag_mismatch("unexpected result steps", '0, 128'(steps));
      end else begin
        want = walk_results.pop_front();
        if (steps !== want.steps) flag_mismatch("steps", 128'(want.steps), 128'(steps));
        if (peak_low !== want.peak[63:0]) begin
          flag_mismatch("peak_low", 128'(want.peak[63:0]), 128'(peak_low));
        end
        if (peak_high !== want.peak[127:64]) begin
          flag_mismatch("peak_high", 128'(want.peak[127:64]), 128'(peak_high));
        end
        if (status !== want.status) begin
          flag_mismatch("status", 128'(want.status), 128'(status));
        end
      end
    end
  end

  initial begin : run_stimulus
    bit [31:0] limits [6];
    foreach (memo_copy[i]) memo_copy[i] = csc_pkg::MEMO_UNKNOWN;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // Directed part, run at the reset step limit.
    queue_seed(128'd0);
    queue_seed(128'd1);
    queue_seed(128'd2);
    queue_seed(128'd27);
    queue_seed('1);
    queue_seed(csc_pkg::SAFE_LIMIT + 1);
    queue_seed(csc_pkg::SAFE_LIMIT - 1);
    queue_seed(128'd1 << 127);
    queue_seed({64'd1, 64'd0});
    queue_memo(16'd5, 32'd1000);
    queue_seed(128'd10);
    queue_seed(128'd5);
    queue_memo(16'd16, 32'hFFFF_FFFE);
    queue_seed(128'd32);
    // A power of two is halved down to one in strip passes without any memo lookup.
    queue_seed(128'd1 << 104);
    queue_memo(16'd16, csc_pkg::MEMO_UNKNOWN);
    queue_seed(128'd32);
    queue_memo(16'hFFFF, 32'd0);
    queue_seed(128'hFFFF);
    queue_memo(16'd1, 32'd7);
    queue_seed(128'd2);
    queue_seed({$urandom, $urandom, $urandom, $urandom});

    limits[0] = 32'd0;
    limits[1] = $urandom_range(1, 64);
    limits[2] = 32'hFFFF_FFFF;
    limits[3] = $urandom_range(200, 3000);
    limits[4] = csc_pkg::FUSE_DEFAULT;
    limits[5] = $urandom_range(1, 20);
    foreach (limits[p]) begin
      set_step_limit(limits[p]);
      idle_pct = (p == 3) ? 0 : 22;
      repeat (PHASE_ITEMS) queue_random_request();
    end

    wait_for_drain();
    if (walk_results.size() != 0) flag_mismatch("leftover expected results", '0, '0);
    if (mismatch_count == 0) begin
      $display("** collatz_step_count_memo: PASSED **");
    end else begin
      $display("** collatz_step_count_memo: FAILED **");
    end
    $finish;
  end

  initial begin : run_limit
    #50_000_000;
    $display("** collatz_step_count_memo: FAILED **");
    $finish;
  end

endmodule
